[sv/rrc_pkg.sv]
// Shared types, constants and the CRC step for the read-holding response checker.
`timescale 1ns / 1ps
package rrc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0]  FUNC_EXC_BIT      = 8'h80;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [7:0]  SLAVE_RESET       = 8'h01;
	localparam logic [8:0]  POS_MAX           = 9'd511;
	localparam logic [8:0]  HDR_LEN           = 9'd3;
	localparam logic [8:0]  MIN_LEN           = 9'd5;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_EXC     = 3'd2,
		ST_UNEXP   = 3'd3,
		ST_CRC_ERR = 3'd4
	} status_t;

	typedef enum logic {
		KIND_DATA   = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	// one queue entry: what one received byte produced
	typedef struct packed {
		logic       has_data;
		logic [7:0] data_byte;
		logic       has_status;
		status_t    status;
		logic [7:0] frame_count;
	} rrc_entry_t;

	// one output word
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		status_t    status;
		logic [7:0] frame_count;
		logic       last;
	} rrc_word_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[sv/rrc_front.sv]
// Front end: takes received bytes, tracks frame fields and CRC, classifies each byte.
`timescale 1ns / 1ps
module rrc_front import rrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       end_of_frame,
	input  logic       cfg_valid,
	input  logic [7:0] cfg_data,
	input  logic       q_full,
	output logic       q_push,
	output rrc_entry_t q_entry
);

	logic [7:0]  exp_slave_q;
	logic [8:0]  pos_q;
	logic [7:0]  slave_q;
	logic [7:0]  func_q;
	logic [7:0]  count_q;
	logic [15:0] crc_q;
	logic [15:0] rep_crc_q;

	logic [8:0]  pos_d;
	logic [7:0]  slave_d;
	logic [7:0]  func_d;
	logic [7:0]  count_d;
	logic [15:0] crc_d;
	logic [15:0] rep_crc_d;
	logic [8:0]  total;
	logic [8:0]  total_d;
	logic [15:0] crc_step;
	logic        is_data;
	status_t     st;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign crc_step = crc_byte(crc_q, rx_byte);

	always_comb begin
		total     = MIN_LEN + {1'b0, count_q};
		slave_d   = slave_q;
		func_d    = func_q;
		count_d   = count_q;
		crc_d     = crc_q;
		rep_crc_d = rep_crc_q;
		is_data   = 1'b0;
		if (pos_q < HDR_LEN) begin
			if (pos_q == 9'd0) begin
				slave_d = rx_byte;
			end else if (pos_q == 9'd1) begin
				func_d = rx_byte;
			end else begin
				count_d = rx_byte;
			end
			crc_d = crc_step;
		end else if (pos_q < total - 9'd2) begin
			crc_d   = crc_step;
			is_data = 1'b1;
		end else if (pos_q == total - 9'd2) begin
			rep_crc_d = {rep_crc_q[15:8], rx_byte};
		end else if (pos_q == total - 9'd1) begin
			rep_crc_d = {rx_byte, rep_crc_q[7:0]};
		end
		pos_d = (pos_q < POS_MAX) ? pos_q + 9'd1 : pos_q;

		// frame verdict on the state after this byte
		total_d = MIN_LEN + {1'b0, count_d};
		if (pos_d < MIN_LEN) begin
			st = ST_SHORT;
		end else if ((func_d & FUNC_EXC_BIT) != 8'h00) begin
			st = ST_EXC;
		end else if (func_d != FUNC_READ_HOLDING || slave_d != exp_slave_q) begin
			st = ST_UNEXP;
		end else if (pos_d < total_d) begin
			st = ST_SHORT;
		end else if (rep_crc_d != crc_d) begin
			st = ST_CRC_ERR;
		end else begin
			st = ST_OK;
		end

		q_entry.has_data    = is_data;
		q_entry.data_byte   = rx_byte;
		q_entry.has_status  = end_of_frame;
		q_entry.status      = st;
		q_entry.frame_count = count_d;
		q_push              = accept && (is_data || end_of_frame);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slave_q <= SLAVE_RESET;
		end else if (cfg_valid) begin
			exp_slave_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			slave_q   <= '0;
			func_q    <= '0;
			count_q   <= '0;
			crc_q     <= CRC_INIT;
			rep_crc_q <= '0;
		end else if (accept) begin
			if (end_of_frame) begin
				pos_q     <= '0;
				slave_q   <= '0;
				func_q    <= '0;
				count_q   <= '0;
				crc_q     <= CRC_INIT;
				rep_crc_q <= '0;
			end else begin
				pos_q     <= pos_d;
				slave_q   <= slave_d;
				func_q    <= func_d;
				count_q   <= count_d;
				crc_q     <= crc_d;
				rep_crc_q <= rep_crc_d;
			end
		end
	end

endmodule

[sv/rrc_fifo.sv]
// Short queue of classified entries between front and back ends.
`timescale 1ns / 1ps
module rrc_fifo import rrc_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rrc_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output rrc_entry_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	rrc_entry_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_wr;
	logic            do_rd;

	assign full  = (count_q == CntFull);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

[sv/rrc_back.sv]
// Back end: expands queue entries into output words behind an output register.
`timescale 1ns / 1ps
module rrc_back import rrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  rrc_entry_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output rrc_word_t  out_word
);

	rrc_word_t out_q;
	logic      out_valid_q;
	rrc_word_t pend_q;
	logic      pend_valid_q;
	logic      load;
	rrc_word_t data_w;
	rrc_word_t stat_w;

	always_comb begin
		data_w.kind        = KIND_DATA;
		data_w.data_byte   = q_head.data_byte;
		data_w.status      = ST_OK;
		data_w.frame_count = '0;
		data_w.last        = 1'b0;
		stat_w.kind        = KIND_STATUS;
		stat_w.data_byte   = '0;
		stat_w.status      = q_head.status;
		stat_w.frame_count = q_head.frame_count;
		stat_w.last        = 1'b1;
	end

	assign load      = !out_valid_q || out_ready;
	assign q_pop     = load && !pend_valid_q && !q_empty;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q  <= 1'b1;
				// data word goes first, status held back one word
				pend_valid_q <= q_head.has_data && q_head.has_status;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (!q_empty) begin
				out_q  <= q_head.has_data ? data_w : stat_w;
				pend_q <= stat_w;
			end
		end
	end

endmodule

[sv/read_holding_response_checker.sv]
// Top level of the read-holding-registers response checker.
`timescale 1ns / 1ps
// Takes one received response byte per cycle on the slave stream, tlast marking
// the frame's final byte. Register data bytes leave as tentative words as soon as
// they arrive; the final byte produces one status word (tlast high) carrying the
// verdict and the frame's byte-count field. A final byte that is also a data byte makes
// two output words, the data word first and then the status word; a queue of
// QueueDepth entries between the byte classifier and the output stage absorbs
// that and output stalls, and input is held off only when the queue is full.
// The expected slave address is written over the cfg channel, which is always ready.
module read_holding_response_checker import rrc_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tlast,   // end_of_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [10:8] status, [18:11] count
	output logic        m_axis_tuser,   // [0] kind
	output logic        m_axis_tlast,   // last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data        // slave address to match
);

	rrc_entry_t q_entry;
	rrc_entry_t q_head;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	rrc_word_t  word;

	assign cfg_ready = 1'b1;

	rrc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.rx_byte      (s_axis_tdata),
		.end_of_frame (s_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_entry)
	);

	rrc_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.empty      (q_empty),
		.head       (q_head)
	);

	rrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (word)
	);

	assign m_axis_tdata = {5'd0, word.frame_count, word.status, word.data_byte};
	assign m_axis_tuser = word.kind;
	assign m_axis_tlast = word.last;

endmodule
